FILE: hdl/mbd_pkg.sv
// Package for the mipmap 2x2 box downsampler: sizes, register indexes,
// the control struct between stages and the lane arithmetic helpers.
// No dependencies.
package mbd_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 12;
  localparam int DIM_W       = 13;
  localparam int LANES       = 4;
  localparam int LANE_W      = 8;
  localparam int SUM_W       = 9;
  localparam int PIX_W       = LANES * LANE_W;
  localparam int PAIR_W      = LANES * SUM_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;
  localparam logic [DIM_W-1:0] DIM_MIN   = 13'd2;
  localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  // Line store access issued by the front stage for one item
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
    logic             last;
  } store_ctrl_t;

  // Lane-wise sum of two pixels, four 9-bit sums at 9-bit spacing
  function automatic logic [PAIR_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PAIR_W-1:0] r;
    r = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      r[lane*SUM_W +: SUM_W] = {1'b0, a[lane*LANE_W +: LANE_W]}
                             + {1'b0, b[lane*LANE_W +: LANE_W]};
    end
    return r;
  endfunction

  // Add two packed pair sums per lane, divide by four (drop two bits)
  function automatic logic [PIX_W-1:0] block_mean(input logic [PAIR_W-1:0] upper,
                                                  input logic [PAIR_W-1:0] lower);
    logic [PIX_W-1:0] r;
    logic [SUM_W:0]   s;
    r = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      s = {1'b0, upper[lane*SUM_W +: SUM_W]} + {1'b0, lower[lane*SUM_W +: SUM_W]};
      r[lane*LANE_W +: LANE_W] = s[SUM_W:2];
    end
    return r;
  endfunction

endpackage

FILE: hdl/mbd_front.sv
// Front stage: configuration registers, column/row counters, left pixel
// hold and pair sums; issues line store writes and reads. Uses mbd_pkg.
module mbd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_fire,
  input  logic [mbd_pkg::PIX_W-1:0]     pixel_in,
  output mbd_pkg::store_ctrl_t          ctrl,
  output logic [mbd_pkg::PAIR_W-1:0]    pair
);
  import mbd_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] hold_r;
  logic [DIM_W-1:0] w, h, used_w, used_h;
  logic [DIM_W-1:0] col_x, row_x;
  logic             active;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  width_r  <= cfg_data;
        REG_SOURCE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped dimensions and the even part actually used
  always_comb begin
    w = (width_r < DIM_MIN) ? DIM_MIN : ((width_r > WIDTH_MAX) ? WIDTH_MAX : width_r);
    h = (height_r < DIM_MIN) ? DIM_MIN : ((height_r > HEIGHT_MAX) ? HEIGHT_MAX : height_r);
    used_w = {w[DIM_W-1:1], 1'b0};
    used_h = {h[DIM_W-1:1], 1'b0};
    col_x  = {1'b0, col_r};
    row_x  = {1'b0, row_r};
    active = (col_x < used_w) && (row_x < used_h);
  end

  // Store access and pair sum for the current item
  always_comb begin
    pair       = pair_sum(hold_r, pixel_in);
    ctrl.idx   = col_r[CNT_W-1:1];
    ctrl.wr_en = in_fire && active && col_r[0] && !row_r[0];
    ctrl.rd_en = in_fire && active && col_r[0] && row_r[0];
    ctrl.last  = (col_x == used_w - 13'd1) && (row_x == used_h - 13'd1);
  end

  // Raster position of the next item
  always_comb begin
    col_nxt = col_r + 12'd1;
    row_nxt = row_r;
    if (col_x + 13'd1 >= w) begin
      col_nxt = '0;
      row_nxt = (row_x + 13'd1 >= h) ? '0 : row_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (active && !col_r[0]) begin
        hold_r <= pixel_in;
      end
    end
  end

endmodule

FILE: hdl/mbd_line_store.sv
// Line store of first-row pair sums, one entry per pixel pair.
// Single write port, registered read. Uses mbd_pkg.
module mbd_line_store (
  input  logic                       clk,
  input  mbd_pkg::store_ctrl_t       ctrl,
  input  logic [mbd_pkg::PAIR_W-1:0] wr_data,
  output logic [mbd_pkg::PAIR_W-1:0] rd_data
);
  import mbd_pkg::*;

  logic [PAIR_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.idx];
    end
  end

endmodule

FILE: hdl/mbd_mean.sv
// Back stages: holds the second-row pair sum beside the store read data,
// forms the block mean and drives the output register. Uses mbd_pkg.
module mbd_mean (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbd_pkg::store_ctrl_t       ctrl,
  input  logic [mbd_pkg::PAIR_W-1:0] pair,
  input  logic [mbd_pkg::PAIR_W-1:0] rd_data,
  output logic                       s1_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mbd_pkg::PIX_W-1:0]  out_pixel,
  output logic                       out_last
);
  import mbd_pkg::*;

  logic              s1_valid_r;
  logic [PAIR_W-1:0] pair_r;
  logic              last_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_last_r;
  logic              out_en;

  assign out_en   = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || out_en;

  // Stage 1: pair sum waits for the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ctrl.rd_en) begin
      s1_valid_r <= 1'b1;
    end else if (out_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      pair_r <= pair;
      last_r <= ctrl.last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_pixel_r <= block_mean(rd_data, pair_r);
      out_last_r  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

FILE: hdl/mipmap_box_downsample.sv
// Top level of the 2x2 box-filter mip downsampler.
// Instantiates mbd_front, mbd_line_store and mbd_mean; uses mbd_pkg.
//
// Usage:
//   in_*  : source pixels in raster order, one item per pixel (tdata = pixel).
//   out_* : one averaged pixel per 2x2 block; tuser flags the last block
//           of the level.
//   cfg_* : register writes (0 = source_width, 1 = source_height), always
//           ready; write only while the block is idle.
// Odd last columns and rows are consumed and produce nothing.
// Throughput: one input item per cycle sustained unless the output stalls. Each result
// is registered in the store read register, then in the output register, after the
// item that completes its block is accepted.
// Reset: counters return to row 0 column 0, dimensions to 256x256. The line
// store is not cleared; it needs no clearing pass since every read follows
// a write in the same frame.
// Stall: while out_tready is low a result waits in the output register and
// one more waits in the read stage; in_tready drops only when both are full.
module mipmap_box_downsample (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] pixel_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [31:0] pixel_out
  output logic                          out_tuser   // [0] frame_done
);
  import mbd_pkg::*;

  store_ctrl_t       ctrl;
  logic [PAIR_W-1:0] pair;
  logic [PAIR_W-1:0] rd_data;
  logic              s1_ready;
  logic              in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && s1_ready;

  mbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .pixel_in  (in_tdata),
    .ctrl      (ctrl),
    .pair      (pair)
  );

  mbd_line_store u_store (
    .clk     (clk),
    .ctrl    (ctrl),
    .wr_data (pair),
    .rd_data (rd_data)
  );

  mbd_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .pair      (pair),
    .rd_data   (rd_data),
    .s1_ready  (s1_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tuser)
  );

endmodule

FILE: hdl/mbd_checker.sv
// Port-level checker for mipmap_box_downsample, attached by bind.
// Watches the input and output handshakes only; no dependencies.
module mbd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // Result is held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Input backpressure only while the output holds a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

  // A fresh result comes from an accepted item, through the read stage and output register
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input item");

endmodule

bind mipmap_box_downsample mbd_checker u_chk (.*);

FILE: verif/mbd_block_checker.sv
`timescale 1ns / 1ps
// Block checker for mipmap_box_downsample. It watches the cfg, in and out channels,
// predicts every averaged 2x2 block and compares each result item with that prediction.
// Depends on mbd_pkg.
module mbd_block_checker
  import mbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] pixel_in
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,  // [31:0] pixel_out
  input  logic                 out_tuser,  // [0] frame_done
  output int                   mismatches,
  output int                   outstanding
);

  localparam int BLOCK_PIXELS = 4;
  localparam int SHOW_LIMIT   = 20;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_done;
  } block_t;

  // Shadow of the registers and of the raster position
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [PIX_W-1:0]   left_pixel;
  // Upper row pixels of each column pair: {right, left}
  logic [2*PIX_W-1:0] upper_pixels [STORE_DEPTH];
  int                 col_pos;
  int                 row_pos;
  int                 err_count;
  block_t             pending_blocks[$];

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Per byte lane: truncated mean of the four pixels of one block
  function automatic logic [PIX_W-1:0] quad_average(input logic [PIX_W-1:0] p0, p1, p2, p3);
    logic [PIX_W-1:0] avg;
    int               total;
    for (int lane = 0; lane < LANES; lane++) begin
      total = p0[lane*LANE_W +: LANE_W] + p1[lane*LANE_W +: LANE_W]
            + p2[lane*LANE_W +: LANE_W] + p3[lane*LANE_W +: LANE_W];
      avg[lane*LANE_W +: LANE_W] = LANE_W'(total / BLOCK_PIXELS);
    end
    return avg;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= SHOW_LIMIT) $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    block_t want;
    int     w, h, used_w, used_h, idx;
    if (!rst_n) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      left_pixel = '0;
      col_pos    = 0;
      row_pos    = 0;
      err_count  = 0;
      pending_blocks.delete();
    end else begin
      // Result side first: a result never belongs to an item taken at the same edge
      if (out_tvalid && out_tready) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch($sformatf("result %h with no block pending", out_tdata));
        end else begin
          want = pending_blocks.pop_front();
          if (out_tdata !== want.pixel)
            report_mismatch($sformatf("pixel_out %h, expected %h", out_tdata, want.pixel));
          if (out_tuser !== want.frame_done)
            report_mismatch($sformatf("frame_done %b, expected %b (pixel %h)",
                                      out_tuser, want.frame_done, want.pixel));
        end
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_SOURCE_HEIGHT) height_reg = cfg_data;
      end

      // Source pixel: update raster position and predict a block if one completes
      if (in_tvalid && in_tready) begin
        w      = clamp_dim(width_reg, MAX_WIDTH);
        h      = clamp_dim(height_reg, MAX_HEIGHT);
        used_w = w - (w % 2);
        used_h = h - (h % 2);
        if (col_pos < used_w && row_pos < used_h) begin
          idx = col_pos / 2;
          if (col_pos % 2 == 0) begin
            left_pixel = in_tdata;
          end else if (row_pos % 2 == 0) begin
            upper_pixels[idx] = {in_tdata, left_pixel};
          end else begin
            want.pixel = quad_average(upper_pixels[idx][PIX_W-1:0],
                                      upper_pixels[idx][2*PIX_W-1:PIX_W],
                                      left_pixel, in_tdata);
            want.frame_done = (col_pos == used_w - 1) && (row_pos == used_h - 1);
            pending_blocks.push_back(want);
          end
        end
        if (col_pos + 1 >= w) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= pending_blocks.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for mipmap_box_downsample: clock, reset, register writes and source
// frames with random gaps and stalls. It uses mbd_pkg and mbd_block_checker for checking.
module tb;
  import mbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 520;
  localparam int IDLE_PCT     = 32;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DIM_W-1:0]     cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;   // [31:0] pixel_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;         // [31:0] pixel_out
  logic                 out_tuser;         // [0] frame_done
  int                   mismatches;
  int                   outstanding;
  int                   pixels_sent = 0;
  int                   quiet_cycles = 0;
  bit                   no_gaps = 1'b0;

  always #1 clk = ~clk;

  mipmap_box_downsample u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mbd_block_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver stalls
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int effective_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Mostly random pixels, with saturated and empty lanes now and then
  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // hold keeps cfg_valid up for a write that follows directly
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic push_pixel(input logic [31:0] px);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      // occasional sender pause until every pending block is out
      if ($urandom_range(0, 199) == 0) hold_until_drained();
      push_pixel(pick_pixel());
    end
  endtask

  // Also lets dropped-edge items that end no block leave the pipeline
  task automatic drain();
    hold_until_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_write(REG_SOURCE_WIDTH, w, 1'b1);
    cfg_write(REG_SOURCE_HEIGHT, h, 1'b0);
    send_pixels(effective_dim(w, MAX_WIDTH) * effective_dim(h, MAX_HEIGHT));
    drain();
  endtask

  initial begin
    logic [DIM_W-1:0] w, h;
    int               sel;
    int               frame_no;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size 256x256: one row pair, then a mid-frame shrink to 2x2 at row 2.
    // Row 2 lies beyond the new height, is consumed and wraps the frame.
    send_pixels(512);
    drain();
    cfg_write(REG_SOURCE_WIDTH, '0, 1'b1);
    cfg_write(REG_SOURCE_HEIGHT, 13'd1, 1'b1);
    cfg_write(REG_SPARE_A, DIM_W'($urandom()), 1'b0);
    send_pixels(2);

    // Saturated lanes: largest sums
    for (int i = 0; i < 4; i++) push_pixel('1);
    drain();

    // Odd size: last column and last row dropped
    cfg_write(REG_SPARE_B, DIM_W'($urandom()), 1'b1);
    run_frame(13'd3, 13'd3);

    // Widen at the start of a row pair, mid-frame
    cfg_write(REG_SOURCE_WIDTH, 13'd2, 1'b1);
    cfg_write(REG_SOURCE_HEIGHT, 13'd4, 1'b0);
    send_pixels(4);
    drain();
    cfg_write(REG_SOURCE_WIDTH, 13'd4, 1'b0);
    send_pixels(8);
    drain();

    // Random small frames, a few of them without any gaps or stalls
    frame_no = 0;
    pixels_sent = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      no_gaps = (frame_no >= 3 && frame_no < 7);
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        w = DIM_W'($urandom_range(0, 3));
        h = DIM_W'($urandom_range(0, 3));
      end else begin
        w = DIM_W'($urandom_range(2, 24));
        h = DIM_W'($urandom_range(2, 12));
      end
      run_frame(w, h);
      frame_no++;
    end
    no_gaps = 1'b0;

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
